### rtl/kis_pkg.sv
package kis_pkg;

    localparam int unsigned SORT_KEY_W = 32;
    localparam int unsigned ITEM_IDX_W = 6;

    typedef struct packed {
        logic [SORT_KEY_W-1:0] sort_key;
        logic                  last_item;
    } t_item;

    typedef struct packed {
        logic [ITEM_IDX_W-1:0] item_index;
        logic                  last_result;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;       // write the new key, count it
        logic scan_init;  // rewind the read address, forget the running best
        logic rd_en;      // read one stored key, advance the address
        logic emit;       // hand out the running best
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic set_full;   // next load fills the last slot
        logic addr_last;  // read address sits on the last loaded key
        logic emit_last;  // next emitted index ends the run
    } t_stat;

endpackage

### rtl/kis_ram.sv
module kis_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kis_ctrl.sv
module kis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_item,
    input  kis_pkg::t_stat i_stat,
    output kis_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item || i_stat.set_full) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_wait_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> ($past(r_state) == S_SCAN))
        else $error("wait state not entered from scan");

    a_emit_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_WAIT))
        else $error("emit state not entered from wait");

endmodule

### rtl/kis_dpath.sv
module kis_dpath #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned KEY_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kis_pkg::t_cmd    i_cmd,
    input  kis_pkg::t_item   i_item,
    output kis_pkg::t_stat   o_stat,
    output logic             o_strobe,
    output kis_pkg::t_result o_result
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned KW = kis_pkg::SORT_KEY_W;
    localparam int unsigned OW = kis_pkg::ITEM_IDX_W;

    logic [KEY_BITS-1:0] w_key_in;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [OW-1:0]       w_idx_out;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_emit;
    logic [IW-1:0]       r_addr;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_addr;
    logic                r_found;
    logic [KEY_BITS-1:0] r_best_key;
    logic [IW-1:0]       r_best_idx;
    logic                r_have_prev;
    logic [KEY_BITS-1:0] r_prev_key;
    logic [IW-1:0]       r_prev_idx;
    logic                r_out_vld;
    kis_pkg::t_result    r_out;

    logic                w_above_prev;
    logic                w_better;

    // only the low KEY_BITS bits of the key take part
    if (KEY_BITS > KW) begin : g_key_wide
        assign w_key_in = {{(KEY_BITS - KW){1'b0}}, i_item.sort_key};
    end else if (KEY_BITS == KW) begin : g_key_same
        assign w_key_in = i_item.sort_key;
    end else begin : g_key_narrow
        assign w_key_in = i_item.sort_key[KEY_BITS-1:0];
    end

    if (IW > OW) begin : g_idx_wide
        assign w_idx_out = r_best_idx[OW-1:0];
    end else if (IW == OW) begin : g_idx_same
        assign w_idx_out = r_best_idx;
    end else begin : g_idx_narrow
        assign w_idx_out = {{(OW - IW){1'b0}}, r_best_idx};
    end

    // keys stored at their arrival index
    kis_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_key_in),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_rd_key)
    );

    assign o_stat.set_full  = (r_count == CW'(MAX_ITEMS - 1));
    assign o_stat.addr_last = ((CW'(r_addr) + CW'(1)) == r_count);
    assign o_stat.emit_last = ((r_emit + CW'(1)) == r_count);

    // a pair must come strictly after the one last emitted; among those keep
    // the smallest key, the first address wins on a tie since addresses ascend
    assign w_above_prev = !r_have_prev || (w_rd_key > r_prev_key) ||
                          ((w_rd_key == r_prev_key) && (r_cmp_addr > r_prev_idx));
    assign w_better     = !r_found || (w_rd_key < r_best_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_emit      <= '0;
            r_addr      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            r_out_vld <= i_cmd.emit;
            if (i_cmd.load) begin
                r_count     <= r_count + CW'(1);
                r_emit      <= '0;
                r_have_prev <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.rd_en) begin
                r_addr <= r_addr + IW'(1);
            end
            if (r_cmp_vld && w_above_prev && w_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_emit      <= r_emit + CW'(1);
                r_have_prev <= 1'b1;
                if (o_stat.emit_last) begin
                    r_count <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_addr;
        if (r_cmp_vld && w_above_prev && w_better) begin
            r_best_key <= w_rd_key;
            r_best_idx <= r_cmp_addr;
        end
        if (i_cmd.emit) begin
            r_prev_key        <= r_best_key;
            r_prev_idx        <= r_best_idx;
            r_out.item_index  <= w_idx_out;
            r_out.last_result <= o_stat.emit_last;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    a_emit_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_found)
        else $error("emit without a candidate");

    a_load_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_count < CW'(MAX_ITEMS)))
        else $error("load beyond set capacity");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.last_result) |-> (r_count == '0))
        else $error("set count not cleared after final result");

endmodule

### rtl/key_index_sorter_core.sv
// Loading: one key per cycle; busy stays low until the key that closes the set.
// Sorting n keys: each result takes a scan of the n loaded keys in the key RAM,
// one read per cycle, then a wait state for the last compare and an emit state;
// the index is registered out, and the next pass starts right after the emit.
// Busy is high from the closing key until the final result is emitted.
// Reset (synchronous, active low) empties the set; key RAM contents are kept.
module key_index_sorter_core #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned KEY_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  kis_pkg::t_item   i_item,
    output logic             o_strobe,
    output kis_pkg::t_result o_result
);

    // Command/status link between sequencer and datapath. The datapath owns
    // the key RAM, the set count, the scan address and the running minimum;
    // the sequencer only decides when to load, scan and emit.
    kis_pkg::t_cmd  w_cmd;
    kis_pkg::t_stat w_stat;

    // Sequencer: idle takes keys; the closing key (flagged last, or filling
    // the set) starts a selection pass per result: scan, wait, emit.
    kis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_item (i_item.last_item),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    // Datapath: every pass picks the smallest (key, index) pair above the one
    // emitted before, so indices leave in ascending key order and equal keys
    // leave by ascending arrival index. Results are registered: each beat is
    // on o_result for exactly one cycle with o_strobe high.
    kis_dpath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

### test/key_index_sorter_core_tb.sv
`timescale 1ns / 100ps

module key_index_sorter_core_tb;

    localparam int unsigned SORT_KEY_W  = kis_pkg::SORT_KEY_W;
    localparam int unsigned ITEM_IDX_W  = kis_pkg::ITEM_IDX_W;
    localparam int unsigned MAX_ITEMS   = 64;
    localparam int unsigned KEY_BITS    = 32;
    localparam int unsigned CLK_HALF_NS = 10;
    localparam int unsigned RESET_CYCLES = 6;
    // Total key budget after the directed sets; phases split it by idle rate.
    localparam int unsigned RAND_KEYS   = 330;
    localparam int unsigned PHASE1_END  = 140;
    localparam int unsigned PHASE2_END  = 250;
    // Worst run is a few full sets, each sorted by one full scan per result; allow far more.
    localparam int unsigned TIMEOUT_NS  = 10_000_000;
    // Drain window after the last index: more than one scan of a full set.
    localparam int unsigned DRAIN_CYCLES = 2 * (MAX_ITEMS + 3);
    localparam logic [SORT_KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= SORT_KEY_W) ? '1 : SORT_KEY_W'((64'd1 << KEY_BITS) - 1);

    // Predict the sorted index run of each set and check the strobed results
    // against it, oldest first.
    class sorted_index_board;
        logic [SORT_KEY_W-1:0] chain_key [MAX_ITEMS];
        logic [ITEM_IDX_W-1:0] chain_idx [MAX_ITEMS];
        int unsigned           fill      = 0;
        kis_pkg::t_result      sorted_q[$];
        int unsigned           mismatches = 0;
        int unsigned           checked    = 0;
        int unsigned           sets_done  = 0;
        int unsigned           full_sets  = 0;

        // Insert the key behind every stored key not greater than it, so
        // equal keys keep arrival order; on the closing key queue the run.
        function void note_key(kis_pkg::t_item beat);
            logic [SORT_KEY_W-1:0] key;
            int unsigned           pos;
            kis_pkg::t_result      res;
            if (fill >= MAX_ITEMS)
                fill = 0;
            key = beat.sort_key & KEY_MASK;
            pos = fill;
            while (pos > 0 && chain_key[pos-1] > key) begin
                chain_key[pos] = chain_key[pos-1];
                chain_idx[pos] = chain_idx[pos-1];
                pos--;
            end
            chain_key[pos] = key;
            chain_idx[pos] = fill[ITEM_IDX_W-1:0];
            fill++;
            if (beat.last_item || fill == MAX_ITEMS) begin
                if (fill == MAX_ITEMS)
                    full_sets++;
                for (int unsigned k = 0; k < fill; k++) begin
                    res.item_index  = chain_idx[k];
                    res.last_result = (k + 1 == fill);
                    sorted_q.insert(sorted_q.size(), res);
                end
                fill = 0;
                sets_done++;
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_index(kis_pkg::t_result got);
            kis_pkg::t_result want;
            checked++;
            if (sorted_q.size() == 0) begin
                flag_mismatch($sformatf("index %0d (last %0b) with nothing pending",
                                        got.item_index, got.last_result));
                return;
            end
            want = sorted_q.pop_front();
            if (got.item_index !== want.item_index)
                flag_mismatch($sformatf("item_index %0d, expected %0d",
                                        got.item_index, want.item_index));
            if (got.last_result !== want.last_result)
                flag_mismatch($sformatf("last_result %0b on index %0d, expected %0b",
                                        got.last_result, got.item_index,
                                        want.last_result));
        endtask

        function int unsigned pending();
            return sorted_q.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    kis_pkg::t_item   i_item;
    logic             o_strobe;
    kis_pkg::t_result o_result;

    sorted_index_board sb;
    int unsigned       keys_sent = 0;

    key_index_sorter_core #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops results.
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Results cannot be held off: take every strobed beat as it comes.
    // Sampling right at the edge sees the values from the cycle that ends.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_index(o_result);
    end

    // Count idle cycles in front of a beat: each cycle stays idle with the
    // given chance, capped so a long run cannot starve the test.
    function automatic int unsigned idle_gap(int unsigned pct);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < pct && gap < 40)
            gap++;
        return gap;
    endfunction

    // Present one key, hold start until a clear busy lets the beat in, then
    // note it. Start stays high on return so back-to-back beats need no toggle.
    task automatic send_key(input logic [SORT_KEY_W-1:0] key, input logic is_last,
                            input int unsigned gap);
        kis_pkg::t_item beat;
        beat.sort_key  = key;
        beat.last_item = is_last;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        sb.note_key(beat);
        keys_sent++;
    endtask

    // Mix wide random keys with a narrow range (many ties), the extremes and
    // keys near the top of the Q16.16 range.
    function automatic logic [SORT_KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 7);
            7:          return '0;
            8:          return '1;
            default:    return {16'hFFFF, 16'($urandom)};
        endcase
    endfunction

    // Send one set of random keys. A set shorter than MAX_ITEMS must close
    // with last_item; a full set closes on its own, so its flag is free.
    task automatic send_set(input int unsigned size, input logic close_full,
                            input int unsigned pct);
        logic is_last;
        for (int unsigned i = 0; i < size; i++) begin
            if (i + 1 < size)
                is_last = 1'b0;
            else
                is_last = (size == MAX_ITEMS) ? close_full : 1'b1;
            send_key(pick_key(), is_last, idle_gap(pct));
        end
    endtask

    // Directed sets: a lone key; the extremes with a tie at zero; a run of
    // equal keys; a descending and an ascending run.
    localparam int unsigned DIR_N = 23;
    localparam logic [SORT_KEY_W-1:0] DIR_KEYS [DIR_N] = '{
        32'h0000_0000,
        32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
        32'h0001_0000,
        32'h0000_0400, 32'h0000_0300, 32'h0000_0200, 32'h0000_0100, 32'h0000_0001,
        32'h0000_0000,
        32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 32'hFFFF_FFFE
    };
    localparam logic [DIR_N-1:0] DIR_LAST = 23'b100_0010_0000_1000_0010_0001;

    initial begin
        int unsigned set_no;
        int unsigned pct;
        int unsigned size;
        int unsigned done;
        logic        close_full;

        sb = new;
        // Hold every input at a known value through reset.
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: back to back, no idling.
        for (int unsigned i = 0; i < DIR_N; i++)
            send_key(DIR_KEYS[i], DIR_LAST[i], 0);

        // Random part. First set fills up without last_item to force the
        // sort; the next one is full and flagged last as well. After that
        // most sets are short, a few mid-sized, a few full.
        set_no = 0;
        while (keys_sent < DIR_N + RAND_KEYS) begin
            done = keys_sent - DIR_N;
            if (done < PHASE1_END)
                pct = 0;
            else if (done < PHASE2_END)
                pct = 82;
            else
                pct = 8;
            close_full = 1'($urandom_range(0, 1));
            if (set_no == 0) begin
                size       = MAX_ITEMS;
                close_full = 1'b0;
            end else if (set_no == 1) begin
                size       = MAX_ITEMS;
                close_full = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0:       size = MAX_ITEMS;
                    1, 2:    size = $urandom_range(9, MAX_ITEMS - 1);
                    default: size = $urandom_range(1, 8);
                endcase
            end
            send_set(size, close_full, pct);
            set_no++;
        end
        start <= 1'b0;

        // Drain: wait for every pending index, then watch for strays.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d keys in %0d sets (%0d closed by a full chain), %0d indices checked",
                 keys_sent, sb.sets_done, sb.full_sets, sb.checked);
        $display("Idle mixes: none, sender 82%%, sender 8%%; %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
